// ===== rtl/ste_pkg.sv =====
// Shared types and codes for the sorted table engine.
`timescale 1ns / 1ps

package ste_pkg;

  // Command codes on the input word.
  localparam logic [1:0] OP_INSERT = 2'd0;
  localparam logic [1:0] OP_DELETE = 2'd1;
  localparam logic [1:0] OP_SEARCH = 2'd2;
  localparam logic [1:0] OP_CLEAR  = 2'd3;

  // Result status codes.
  localparam logic [1:0] ST_OK      = 2'd0;
  localparam logic [1:0] ST_FULL    = 2'd1;
  localparam logic [1:0] ST_MISSING = 2'd2;

  typedef enum logic [2:0] {
    IDX_HOLD = 3'd0,
    IDX_ZERO = 3'd1,
    IDX_TOP  = 3'd2,
    IDX_INC  = 3'd3,
    IDX_DEC  = 3'd4
  } idx_op_t;

  typedef enum logic [1:0] {
    WR_NONE     = 2'd0,
    WR_SHIFT_UP = 2'd1,
    WR_SHIFT_DN = 2'd2,
    WR_PLACE    = 2'd3
  } wr_sel_t;

  typedef enum logic [1:0] {
    POS_HOLD = 2'd0,
    POS_ZERO = 2'd1,
    POS_IDX  = 2'd2,
    POS_IDX1 = 2'd3
  } pos_sel_t;

  typedef enum logic [1:0] {
    CNT_HOLD = 2'd0,
    CNT_INC  = 2'd1,
    CNT_DEC  = 2'd2,
    CNT_CLR  = 2'd3
  } cnt_op_t;

  typedef struct packed {
    logic       load;
    idx_op_t    idx_op;
    logic       rd_en;
    wr_sel_t    wr_sel;
    pos_sel_t   pos_sel;
    logic       st_we;
    logic [1:0] st_val;
    cnt_op_t    cnt_op;
    logic       cap_min;
    logic       cap_max;
    logic       out_load;
  } ste_cmd_t;

  typedef struct packed {
    logic empty;
    logic full;
    logic gt;
    logic eq;
    logic idx_zero;
    logic idx_last;
  } ste_stat_t;

endpackage

// ===== rtl/ste_dp.sv =====
// Datapath of the sorted table engine: entry memory, scan index, count and result registers.
`timescale 1ns / 1ps

module ste_dp #(
  parameter int CAPACITY = 128
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic signed [31:0]  in_value,
  input  ste_pkg::ste_cmd_t   cmd,
  output ste_pkg::ste_stat_t  stat,
  output logic [1:0]          res_status,
  output logic [6:0]          res_position,
  output logic [7:0]          res_entry_count,
  output logic signed [31:0]  res_min_value,
  output logic signed [31:0]  res_max_value
);

  localparam int IW = $clog2(CAPACITY);
  localparam int CW = $clog2(CAPACITY + 1);

  logic signed [31:0] mem [CAPACITY];

  logic signed [31:0] rdata_r;
  logic signed [31:0] raw_r;
  logic [IW-1:0]      idx_r, idx_nxt;
  logic [IW-1:0]      pos_r, pos_nxt;
  logic [CW-1:0]      count_r, count_nxt;
  logic [1:0]         status_r;
  logic signed [31:0] min_r, max_r;
  logic               wr_en;
  logic [IW-1:0]      wr_addr;
  logic signed [31:0] wr_data;

  always_comb begin
    case (cmd.idx_op)
      ste_pkg::IDX_HOLD: idx_nxt = idx_r;
      ste_pkg::IDX_ZERO: idx_nxt = '0;
      ste_pkg::IDX_TOP:  idx_nxt = IW'(count_r - CW'(1));
      ste_pkg::IDX_INC:  idx_nxt = idx_r + IW'(1);
      ste_pkg::IDX_DEC:  idx_nxt = idx_r - IW'(1);
      default:           idx_nxt = idx_r;
    endcase
  end

  always_comb begin
    case (cmd.pos_sel)
      ste_pkg::POS_HOLD: pos_nxt = pos_r;
      ste_pkg::POS_ZERO: pos_nxt = '0;
      ste_pkg::POS_IDX:  pos_nxt = idx_r;
      ste_pkg::POS_IDX1: pos_nxt = idx_r + IW'(1);
      default:           pos_nxt = pos_r;
    endcase
  end

  always_comb begin
    case (cmd.cnt_op)
      ste_pkg::CNT_HOLD: count_nxt = count_r;
      ste_pkg::CNT_INC:  count_nxt = count_r + CW'(1);
      ste_pkg::CNT_DEC:  count_nxt = count_r - CW'(1);
      ste_pkg::CNT_CLR:  count_nxt = '0;
      default:           count_nxt = count_r;
    endcase
  end

  // Shifts move the word just read one slot up or down; a place writes the operand.
  always_comb begin
    wr_en   = 1'b1;
    wr_addr = pos_r;
    wr_data = rdata_r;
    case (cmd.wr_sel)
      ste_pkg::WR_NONE:     wr_en = 1'b0;
      ste_pkg::WR_SHIFT_UP: wr_addr = idx_r + IW'(1);
      ste_pkg::WR_SHIFT_DN: wr_addr = idx_r - IW'(1);
      ste_pkg::WR_PLACE: begin
        wr_addr = pos_r;
        wr_data = raw_r;
      end
      default:              wr_en = 1'b0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (cmd.rd_en) begin
      rdata_r <= mem[idx_nxt];
    end
  end

  always_ff @(posedge clk) begin
    idx_r <= idx_nxt;
    pos_r <= pos_nxt;
    if (cmd.load) begin
      raw_r <= in_value;
    end
    if (cmd.st_we) begin
      status_r <= cmd.st_val;
    end
    if (cmd.cap_min) begin
      min_r <= stat.empty ? 32'sd0 : rdata_r;
    end
    if (cmd.cap_max) begin
      max_r <= stat.empty ? 32'sd0 : rdata_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r <= '0;
    end else begin
      count_r <= count_nxt;
    end
  end

  assign stat.empty    = (count_r == '0);
  assign stat.full     = (count_r == CW'(CAPACITY));
  assign stat.gt       = (rdata_r > raw_r);
  assign stat.eq       = (rdata_r == raw_r);
  assign stat.idx_zero = (idx_r == '0);
  assign stat.idx_last = ((CW'(idx_r) + CW'(1)) == count_r);

  assign res_status      = status_r;
  assign res_position    = 7'(pos_r);
  assign res_entry_count = 8'(count_r);
  assign res_min_value   = min_r;
  assign res_max_value   = max_r;

`ifndef ASSERT_OFF
  a_count_range: assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= CW'(CAPACITY))
    else $error("entry count exceeds capacity");

  a_inc_not_full: assert property (@(posedge clk) disable iff (!rst_n)
    (cmd.cnt_op == ste_pkg::CNT_INC) |-> !stat.full)
    else $error("count incremented on a full table");

  a_dec_not_empty: assert property (@(posedge clk) disable iff (!rst_n)
    (cmd.cnt_op == ste_pkg::CNT_DEC) |-> !stat.empty)
    else $error("count decremented on an empty table");
`endif

endmodule

// ===== rtl/ste_ctrl.sv =====
// Controller state machine of the sorted table engine.
`timescale 1ns / 1ps

module ste_ctrl (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  input  logic [1:0]         in_operation,
  input  ste_pkg::ste_stat_t stat,
  input  logic               out_free,
  output ste_pkg::ste_cmd_t  cmd,
  output logic               idle
);

  typedef enum logic [8:0] {
    S_IDLE      = 9'b000000001,
    S_INS_SCAN  = 9'b000000010,
    S_PLACE     = 9'b000000100,
    S_FIND      = 9'b000001000,
    S_DEL_SHIFT = 9'b000010000,
    S_RD_MIN    = 9'b000100000,
    S_RD_MAX    = 9'b001000000,
    S_CAP_MAX   = 9'b010000000,
    S_DONE      = 9'b100000000
  } state_t;

  state_t     state_r, state_nxt;
  logic [1:0] op_r;

  assign idle = (state_r == S_IDLE);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (idle && in_valid) begin
      op_r <= in_operation;
    end
  end

  always_comb begin
    state_nxt    = state_r;
    cmd.load     = 1'b0;
    cmd.idx_op   = ste_pkg::IDX_HOLD;
    cmd.rd_en    = 1'b0;
    cmd.wr_sel   = ste_pkg::WR_NONE;
    cmd.pos_sel  = ste_pkg::POS_HOLD;
    cmd.st_we    = 1'b0;
    cmd.st_val   = ste_pkg::ST_OK;
    cmd.cnt_op   = ste_pkg::CNT_HOLD;
    cmd.cap_min  = 1'b0;
    cmd.cap_max  = 1'b0;
    cmd.out_load = 1'b0;
    case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          cmd.load    = 1'b1;
          cmd.pos_sel = ste_pkg::POS_ZERO;
          cmd.st_we   = 1'b1;
          case (in_operation)
            ste_pkg::OP_INSERT: begin
              if (stat.full) begin
                cmd.st_val = ste_pkg::ST_FULL;
                state_nxt  = S_RD_MIN;
              end else if (stat.empty) begin
                state_nxt = S_PLACE;
              end else begin
                // Walk down from the top entry, moving larger ones up.
                cmd.idx_op = ste_pkg::IDX_TOP;
                cmd.rd_en  = 1'b1;
                state_nxt  = S_INS_SCAN;
              end
            end
            ste_pkg::OP_DELETE, ste_pkg::OP_SEARCH: begin
              if (stat.empty) begin
                cmd.st_val = ste_pkg::ST_MISSING;
                state_nxt  = S_RD_MIN;
              end else begin
                cmd.idx_op = ste_pkg::IDX_ZERO;
                cmd.rd_en  = 1'b1;
                state_nxt  = S_FIND;
              end
            end
            ste_pkg::OP_CLEAR: begin
              cmd.cnt_op = ste_pkg::CNT_CLR;
              state_nxt  = S_RD_MIN;
            end
            default: state_nxt = S_IDLE;
          endcase
        end
      end
      S_INS_SCAN: begin
        if (stat.gt) begin
          cmd.wr_sel = ste_pkg::WR_SHIFT_UP;
          if (stat.idx_zero) begin
            cmd.pos_sel = ste_pkg::POS_ZERO;
            state_nxt   = S_PLACE;
          end else begin
            cmd.idx_op = ste_pkg::IDX_DEC;
            cmd.rd_en  = 1'b1;
          end
        end else begin
          cmd.pos_sel = ste_pkg::POS_IDX1;
          state_nxt   = S_PLACE;
        end
      end
      S_PLACE: begin
        cmd.wr_sel = ste_pkg::WR_PLACE;
        cmd.cnt_op = ste_pkg::CNT_INC;
        state_nxt  = S_RD_MIN;
      end
      S_FIND: begin
        if (stat.eq) begin
          cmd.pos_sel = ste_pkg::POS_IDX;
          if (op_r == ste_pkg::OP_SEARCH) begin
            state_nxt = S_RD_MIN;
          end else if (stat.idx_last) begin
            cmd.cnt_op = ste_pkg::CNT_DEC;
            state_nxt  = S_RD_MIN;
          end else begin
            cmd.idx_op = ste_pkg::IDX_INC;
            cmd.rd_en  = 1'b1;
            state_nxt  = S_DEL_SHIFT;
          end
        end else if (stat.gt || stat.idx_last) begin
          // The scan stops at the first larger entry or at the last entry.
          cmd.st_we  = 1'b1;
          cmd.st_val = ste_pkg::ST_MISSING;
          state_nxt  = S_RD_MIN;
        end else begin
          cmd.idx_op = ste_pkg::IDX_INC;
          cmd.rd_en  = 1'b1;
        end
      end
      S_DEL_SHIFT: begin
        cmd.wr_sel = ste_pkg::WR_SHIFT_DN;
        if (stat.idx_last) begin
          cmd.cnt_op = ste_pkg::CNT_DEC;
          state_nxt  = S_RD_MIN;
        end else begin
          cmd.idx_op = ste_pkg::IDX_INC;
          cmd.rd_en  = 1'b1;
        end
      end
      S_RD_MIN: begin
        cmd.idx_op = ste_pkg::IDX_ZERO;
        cmd.rd_en  = 1'b1;
        state_nxt  = S_RD_MAX;
      end
      S_RD_MAX: begin
        cmd.cap_min = 1'b1;
        if (!stat.empty) begin
          cmd.idx_op = ste_pkg::IDX_TOP;
          cmd.rd_en  = 1'b1;
        end
        state_nxt = S_CAP_MAX;
      end
      S_CAP_MAX: begin
        cmd.cap_max = 1'b1;
        state_nxt   = S_DONE;
      end
      S_DONE: begin
        if (out_free) begin
          cmd.out_load = 1'b1;
          state_nxt    = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

`ifndef ASSERT_OFF
  a_load_only_idle: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.load |-> (state_r == S_IDLE) && in_valid)
    else $error("command captured outside idle");

  a_done_to_idle: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.out_load |=> (state_r == S_IDLE))
    else $error("controller did not return to idle after a result");
`endif

endmodule

// ===== rtl/sorted_table_engine_unit.sv =====
// Sorted table engine: one command at a time over an ascending table of signed values.
// One command in flight; scan and shift walk the entry memory one entry per cycle.
// Reset (synchronous, rst_n low) empties the table; entry contents are not cleared.
`timescale 1ns / 1ps

module sorted_table_engine_unit #(
  parameter int CAPACITY = 128
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_stall,
  input  logic [1:0]         in_operation,
  input  logic signed [31:0] in_value,
  output logic               out_valid,
  input  logic               out_stall,
  output logic [1:0]         out_status,
  output logic [6:0]         out_position,
  output logic [7:0]         out_entry_count,
  output logic signed [31:0] out_min_value,
  output logic signed [31:0] out_max_value
);

  ste_pkg::ste_cmd_t  cmd;
  ste_pkg::ste_stat_t stat;

  logic               idle;
  logic               out_free;
  logic               out_valid_r, out_valid_nxt;
  logic [1:0]         res_status;
  logic [6:0]         res_position;
  logic [7:0]         res_entry_count;
  logic signed [31:0] res_min_value, res_max_value;
  logic [1:0]         status_r;
  logic [6:0]         position_r;
  logic [7:0]         entry_count_r;
  logic signed [31:0] min_value_r, max_value_r;

  ste_ctrl u_ctrl (
    .clk          (clk),
    .rst_n        (rst_n),
    .in_valid     (in_valid),
    .in_operation (in_operation),
    .stat         (stat),
    .out_free     (out_free),
    .cmd          (cmd),
    .idle         (idle)
  );

  ste_dp #(
    .CAPACITY (CAPACITY)
  ) u_dp (
    .clk             (clk),
    .rst_n           (rst_n),
    .in_value        (in_value),
    .cmd             (cmd),
    .stat            (stat),
    .res_status      (res_status),
    .res_position    (res_position),
    .res_entry_count (res_entry_count),
    .res_min_value   (res_min_value),
    .res_max_value   (res_max_value)
  );

  assign in_stall = !idle;

  // The output word register frees up in the same cycle its word is taken.
  assign out_free = !out_valid_r || !out_stall;

  always_comb begin
    out_valid_nxt = out_valid_r;
    if (cmd.out_load) begin
      out_valid_nxt = 1'b1;
    end else if (out_valid_r && !out_stall) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.out_load) begin
      status_r      <= res_status;
      position_r    <= res_position;
      entry_count_r <= res_entry_count;
      min_value_r   <= res_min_value;
      max_value_r   <= res_max_value;
    end
  end

  assign out_valid       = out_valid_r;
  assign out_status      = status_r;
  assign out_position    = position_r;
  assign out_entry_count = entry_count_r;
  assign out_min_value   = min_value_r;
  assign out_max_value   = max_value_r;

`ifndef ASSERT_OFF
  a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.out_load |-> out_free)
    else $error("result loaded over a word not yet taken");
`endif

endmodule
